>>> rtl/first_fit_block_allocator_macros.svh
// Assertion macros for the allocator's checker file
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ffba_pkg.sv
// Shared codes and types for the first-fit block allocator
package ffba_pkg;

   localparam int STATUS_W = 3;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOMEM   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NULL    = 3'd4;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // table port enables
   typedef struct packed {
      logic rd;
      logic wr;
   } tbl_en_type;

endpackage

>>> rtl/first_fit_block_allocator.sv
// Top level: first-fit allocator with heap limit register, sequencer and block table
//
//   channel   ports                          handshake
//   request   req_command/size/address       start high and busy low
//   result    rsp_status, rsp_result_address rsp_valid, one cycle, no back-pressure
//   config    csr_write_data                 csr_write_enable
//
// Zero-size allocate and null free: result beat in the cycle after the accept.
// Other requests scan the block table one entry per cycle through its single
// read port; the scan stops at the first match, and with no match it ends after
// the last entry, and the result beat is registered from there. busy drops
// in the result cycle, so a new request can enter then; the receiver never stalls.
// Synchronous reset empties the table and sets the limit to 2^HEAP_ADDR_BITS.
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS     = 64,
   parameter int HEAP_ADDR_BITS = 20,
   parameter int HEADER_BYTES   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [HEAP_ADDR_BITS-1:0]     req_request_size,
   input  logic [HEAP_ADDR_BITS-1:0]     req_payload_address,
   output logic                          rsp_valid,
   output logic [ffba_pkg::STATUS_W-1:0] rsp_status,
   output logic [HEAP_ADDR_BITS-1:0]     rsp_result_address,
   input  logic                          csr_write_enable,
   input  logic [HEAP_ADDR_BITS:0]       csr_write_data
);

   localparam int A  = HEAP_ADDR_BITS;
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int DW = 2 * A + 1;
   localparam logic [A:0] SPAN = {1'b1, {A{1'b0}}};

   logic [A:0] limit_ff;
   logic [A:0] limit_eff;

   ffba_pkg::tbl_en_type tbl_en;
   logic [IW-1:0]        tbl_rd_addr;
   logic [DW-1:0]        tbl_rd_data;
   logic [IW-1:0]        tbl_wr_addr;
   logic [DW-1:0]        tbl_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= SPAN;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // the break never passes the address span either
   assign limit_eff = (limit_ff > SPAN) ? SPAN : limit_ff;

   ffba_ctrl #(
      .MAX_BLOCKS    (MAX_BLOCKS),
      .HEAP_ADDR_BITS(HEAP_ADDR_BITS),
      .HEADER_BYTES  (HEADER_BYTES),
      .IW            (IW),
      .CW            (CW),
      .DW            (DW)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_request_size   (req_request_size),
      .req_payload_address(req_payload_address),
      .limit              (limit_eff),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address),
      .tbl_en             (tbl_en),
      .tbl_rd_addr        (tbl_rd_addr),
      .tbl_rd_data        (tbl_rd_data),
      .tbl_wr_addr        (tbl_wr_addr),
      .tbl_wr_data        (tbl_wr_data)
   );

   ffba_table #(
      .DEPTH(MAX_BLOCKS),
      .AW   (IW),
      .DW   (DW)
   ) u_table (
      .clock  (clock),
      .en     (tbl_en),
      .rd_addr(tbl_rd_addr),
      .rd_data(tbl_rd_data),
      .wr_addr(tbl_wr_addr),
      .wr_data(tbl_wr_data)
   );

endmodule

>>> rtl/ffba_table.sv
// Block table memory: one write port, one registered read port
module ffba_table #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 41
) (
   input  logic                clock,
   input  ffba_pkg::tbl_en_type en,
   input  logic [AW-1:0]       rd_addr,
   output logic [DW-1:0]       rd_data,
   input  logic [AW-1:0]       wr_addr,
   input  logic [DW-1:0]       wr_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en.wr) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (en.rd) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ffba_ctrl.sv
// Allocator sequencer: table scan, first-fit match, append, pop and result register
module ffba_ctrl #(
   parameter int MAX_BLOCKS     = 64,
   parameter int HEAP_ADDR_BITS = 20,
   parameter int HEADER_BYTES   = 16,
   parameter int IW             = 6,
   parameter int CW             = 7,
   parameter int DW             = 41
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_command,
   input  logic [HEAP_ADDR_BITS-1:0]       req_request_size,
   input  logic [HEAP_ADDR_BITS-1:0]       req_payload_address,
   input  logic [HEAP_ADDR_BITS:0]         limit,
   output logic                            rsp_valid,
   output logic [ffba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [HEAP_ADDR_BITS-1:0]       rsp_result_address,
   output ffba_pkg::tbl_en_type            tbl_en,
   output logic [IW-1:0]                   tbl_rd_addr,
   input  logic [DW-1:0]                   tbl_rd_data,
   output logic [IW-1:0]                   tbl_wr_addr,
   output logic [DW-1:0]                   tbl_wr_data
);

   localparam int A = HEAP_ADDR_BITS;
   localparam logic [A:0]  HDR     = (A+1)'(HEADER_BYTES);
   localparam logic [CW-1:0] FULL  = CW'(MAX_BLOCKS);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic                       state_ff, state_in;
   logic                       cmd_ff, cmd_in;
   logic [A-1:0]               size_ff, size_in;
   logic [A-1:0]               addr_ff, addr_in;
   logic [CW-1:0]              scan_idx_ff, scan_idx_in;
   logic                       pend_ff, pend_in;
   logic [IW-1:0]              pend_idx_ff, pend_idx_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [A:0]                 brk_ff, brk_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ffba_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [A-1:0]               rsp_addr_ff, rsp_addr_in;

   logic [A-1:0] rd_base;
   logic [A-1:0] rd_len;
   logic         rd_free;
   logic [A:0]   rd_payload;
   logic         hit;
   logic         issue;
   logic         is_top;
   logic [A+1:0] end_off;
   logic [A:0]   brk_payload;
   logic         nomem;

   assign rd_base     = tbl_rd_data[DW-1 -: A];
   assign rd_len      = tbl_rd_data[A:1];
   assign rd_free     = tbl_rd_data[0];
   assign rd_payload  = {1'b0, rd_base} + HDR;
   assign is_top      = (CW'(pend_idx_ff) + CW'(1)) == count_ff;
   assign end_off     = {1'b0, brk_ff} + (A+2)'(HDR) + (A+2)'(size_ff);
   assign brk_payload = brk_ff + HDR;
   assign nomem       = (count_ff == FULL) || (end_off > {1'b0, limit});
   assign issue       = scan_idx_ff < count_ff;

   always_comb begin
      if (cmd_ff == ffba_pkg::CMD_ALLOC) begin
         hit = pend_ff && rd_free && (rd_len >= size_ff);
      end else begin
         hit = pend_ff && (rd_payload == {1'b0, addr_ff});
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      scan_idx_in   = scan_idx_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      count_in      = count_ff;
      brk_in        = brk_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      tbl_en        = '0;
      tbl_rd_addr   = scan_idx_ff[IW-1:0];
      tbl_wr_addr   = pend_idx_ff;
      tbl_wr_data   = {rd_base, rd_len, 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in  = req_command;
               size_in = req_request_size;
               addr_in = req_payload_address;
               if (req_command == ffba_pkg::CMD_ALLOC && req_request_size == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ffba_pkg::ST_ZERO;
                  rsp_addr_in   = '0;
               end else if (req_command == ffba_pkg::CMD_FREE &&
                            req_payload_address == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ffba_pkg::ST_NULL;
                  rsp_addr_in   = '0;
               end else begin
                  state_in    = S_SCAN;
                  scan_idx_in = '0;
               end
            end
         end
         S_SCAN: begin
            // reads run one entry ahead of the compare; no writes until the scan ends
            if (hit) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ffba_pkg::ST_OK;
               if (cmd_ff == ffba_pkg::CMD_ALLOC) begin
                  tbl_en.wr   = 1'b1;
                  tbl_wr_data = {rd_base, rd_len, 1'b0};
                  rsp_addr_in = rd_payload[A-1:0];
               end else begin
                  rsp_addr_in = '0;
                  if (is_top) begin
                     // pop: break falls back to this block's header
                     count_in = CW'(pend_idx_ff);
                     brk_in   = {1'b0, rd_base};
                  end else begin
                     tbl_en.wr   = 1'b1;
                     tbl_wr_data = {rd_base, rd_len, 1'b1};
                  end
               end
            end else if (!issue) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_addr_in  = '0;
               if (cmd_ff == ffba_pkg::CMD_FREE) begin
                  rsp_status_in = ffba_pkg::ST_UNKNOWN;
               end else if (nomem) begin
                  rsp_status_in = ffba_pkg::ST_NOMEM;
               end else begin
                  tbl_en.wr     = 1'b1;
                  tbl_wr_addr   = count_ff[IW-1:0];
                  tbl_wr_data   = {brk_ff[A-1:0], size_ff, 1'b0};
                  count_in      = count_ff + CW'(1);
                  brk_in        = end_off[A:0];
                  rsp_status_in = ffba_pkg::ST_OK;
                  rsp_addr_in   = brk_payload[A-1:0];
               end
            end else begin
               tbl_en.rd   = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = scan_idx_ff[IW-1:0];
               scan_idx_in = scan_idx_ff + CW'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_idx_ff  <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         brk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         brk_ff       <= brk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign busy               = reset || (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;

endmodule

>>> rtl/ffba_chk.sv
// Port-level checker for the allocator, bound to the top level
`include "first_fit_block_allocator_macros.svh"

module ffba_chk #(
   parameter int HEAP_ADDR_BITS = 20
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_command,
   input logic [HEAP_ADDR_BITS-1:0]     req_request_size,
   input logic [HEAP_ADDR_BITS-1:0]     req_payload_address,
   input logic                          rsp_valid,
   input logic [ffba_pkg::STATUS_W-1:0] rsp_status,
   input logic [HEAP_ADDR_BITS-1:0]     rsp_result_address
);

   logic accept;
   logic open_ff, open_in;
   logic last_cmd_ff;
   logic zero_alloc;
   logic null_free;
   logic zero_beat;
   logic null_beat;
   logic fail_or_free;
   logic nogrant_beat;
   logic grant_beat;
   logic addr_null;

   assign accept       = start && !busy;
   assign zero_alloc   = accept && req_command == ffba_pkg::CMD_ALLOC &&
                         req_request_size == '0;
   assign null_free    = accept && req_command == ffba_pkg::CMD_FREE &&
                         req_payload_address == '0;
   assign zero_beat    = rsp_valid && rsp_status == ffba_pkg::ST_ZERO;
   assign null_beat    = rsp_valid && rsp_status == ffba_pkg::ST_NULL;
   assign fail_or_free = rsp_status != ffba_pkg::ST_OK || last_cmd_ff == ffba_pkg::CMD_FREE;
   assign nogrant_beat = rsp_valid && fail_or_free;
   assign grant_beat   = rsp_valid && !fail_or_free;
   assign addr_null    = rsp_result_address == '0;

   always_comb begin
      if (accept) begin
         open_in = 1'b1;
      end else if (rsp_valid) begin
         open_in = 1'b0;
      end else begin
         open_in = open_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_cmd_ff <= req_command;
      end
   end

   `FFBA_ASSERT_NEXT(a_zero_size, zero_alloc, zero_beat, "zero-size allocate unanswered")
   `FFBA_ASSERT_NEXT(a_null_free, null_free, null_beat, "null free unanswered")
   `FFBA_ASSERT_NOW(a_rsp_owed, rsp_valid, open_ff, "result beat without an open request")
   `FFBA_ASSERT_NOW(a_addr_zero, nogrant_beat, addr_null, "nonzero address on failure or free")
   `FFBA_ASSERT_NOW(a_addr_clear, grant_beat, !addr_null, "granted payload address is null")

endmodule

bind first_fit_block_allocator ffba_chk #(
   .HEAP_ADDR_BITS(HEAP_ADDR_BITS)
) u_ffba_chk (.*);

>>> tb/first_fit_block_allocator_tb.sv
// Testbench for the first-fit block allocator: directed and random heap traffic against a predictor
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;

   localparam int MAX_BLOCKS = 64;
   localparam int ADDR_W     = 20;
   localparam int HDR        = 16;
   localparam int SPAN       = 1 << ADDR_W;

   typedef struct packed {
      logic              command;
      logic [ADDR_W-1:0] size;
      logic [ADDR_W-1:0] address;
   } heap_req_type;

   typedef struct packed {
      logic [ffba_pkg::STATUS_W-1:0] status;
      logic [ADDR_W-1:0]             address;
   } alloc_outcome_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_command = ffba_pkg::CMD_ALLOC;
   logic [ADDR_W-1:0]             req_request_size = '0;
   logic [ADDR_W-1:0]             req_payload_address = '0;
   logic                          rsp_valid;
   logic [ffba_pkg::STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]             rsp_result_address;
   logic                          csr_write_enable = 1'b0;
   logic [ADDR_W:0]               csr_write_data = '0;

   // heap table as the block should hold it
   logic [ADDR_W-1:0] mdl_base [MAX_BLOCKS];
   logic [ADDR_W-1:0] mdl_len  [MAX_BLOCKS];
   logic              mdl_free [MAX_BLOCKS];
   int unsigned       mdl_count;
   logic [ADDR_W:0]   mdl_break;
   logic [ADDR_W:0]   mdl_limit;

   heap_req_type      pending_requests [$];
   alloc_outcome_type predicted_outcomes [$];
   heap_req_type      drive_req;
   heap_req_type      seen_req;
   alloc_outcome_type want;
   logic              beat_taken = 1'b0;
   logic              gaps_enabled = 1'b1;
   int unsigned       gap_left = 0;
   int unsigned       error_count = 0;

   first_fit_block_allocator u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_request_size    (req_request_size),
      .req_payload_address (req_payload_address),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_result_address  (rsp_result_address),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic alloc_outcome_type apply_heap_op(heap_req_type r);
      alloc_outcome_type o;
      logic [ADDR_W+1:0] top_end;
      logic [ADDR_W:0]   cap;
      bit                found;
      int                i;
      o.status  = ffba_pkg::ST_OK;
      o.address = '0;
      found     = 1'b0;
      if (r.command == ffba_pkg::CMD_ALLOC) begin
         if (r.size == '0) begin
            o.status = ffba_pkg::ST_ZERO;
         end else begin
            // first fit, whole block, no split
            for (i = 0; i < mdl_count; i++) begin
               if (!found && mdl_free[i] && mdl_len[i] >= r.size) begin
                  found       = 1'b1;
                  mdl_free[i] = 1'b0;
                  o.address   = ADDR_W'(mdl_base[i] + HDR);
               end
            end
            if (!found) begin
               cap     = (mdl_limit < SPAN) ? mdl_limit : (ADDR_W+1)'(SPAN);
               top_end = (ADDR_W+2)'(mdl_break + HDR + r.size);
               if (mdl_count >= MAX_BLOCKS || top_end > {1'b0, cap}) begin
                  o.status = ffba_pkg::ST_NOMEM;
               end else begin
                  mdl_base[mdl_count] = mdl_break[ADDR_W-1:0];
                  mdl_len[mdl_count]  = r.size;
                  mdl_free[mdl_count] = 1'b0;
                  o.address           = ADDR_W'(mdl_break + HDR);
                  mdl_count           = mdl_count + 1;
                  mdl_break           = top_end[ADDR_W:0];
               end
            end
         end
      end else if (r.address == '0) begin
         o.status = ffba_pkg::ST_NULL;
      end else begin
         for (i = 0; i < mdl_count; i++) begin
            if (!found && mdl_base[i] + HDR == r.address) begin
               found = 1'b1;
               if (i + 1 == mdl_count) begin
                  // top block pops, break falls to its header
                  mdl_break = {1'b0, mdl_base[i]};
                  mdl_count = i;
               end else begin
                  mdl_free[i] = 1'b1;
               end
            end
         end
         if (!found)
            o.status = ffba_pkg::ST_UNKNOWN;
      end
      return o;
   endfunction

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_requests.size() != 0) begin
            drive_req = pending_requests.pop_front();
            start               <= 1'b1;
            req_command         <= drive_req.command;
            req_request_size    <= drive_req.size;
            req_payload_address <= drive_req.address;
            if (gaps_enabled && $urandom_range(7) == 0)
               gap_left <= $urandom_range(1, 16);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results checked and accepted beats predicted on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (predicted_outcomes.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected result: status %0d address 0x%05h",
                           rsp_status, rsp_result_address);
               error_count++;
            end else begin
               want = predicted_outcomes.pop_front();
               if (rsp_status !== want.status || rsp_result_address !== want.address) begin
                  if (error_count < 10)
                     $display("mismatch: status exp %0d got %0d, address exp 0x%05h got 0x%05h",
                              want.status, rsp_status, want.address, rsp_result_address);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            seen_req.command = req_command;
            seen_req.size    = req_request_size;
            seen_req.address = req_payload_address;
            predicted_outcomes.push_back(apply_heap_op(seen_req));
         end
      end
      beat_taken <= !reset && start && !busy;
   end

   task automatic queue_op(logic cmd, int size, int addr);
      heap_req_type r;
      r.command = cmd;
      r.size    = ADDR_W'(size);
      r.address = ADDR_W'(addr);
      pending_requests.push_back(r);
   endtask

   // wait until every beat has gone in and every result has come back
   task automatic settle_heap();
      @(posedge clock);
      #1;
      while (pending_requests.size() != 0 || start || predicted_outcomes.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_heap_limit(int unsigned value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= (ADDR_W+1)'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      mdl_limit = (ADDR_W+1)'(value);
   endtask

   task automatic run_phase(int n, int alloc_pct, bit gaps);
      heap_req_type    r;
      int              pick;
      int              k;
      logic [ADDR_W:0] cap;
      gaps_enabled = gaps;
      repeat (n) begin
         // keep the backlog short so addresses come from a recent view of the table
         while (pending_requests.size() >= 3)
            @(negedge clock);
         r.size    = ADDR_W'($urandom);
         r.address = ADDR_W'($urandom);
         pick      = $urandom_range(99);
         if ($urandom_range(99) < alloc_pct) begin
            r.command = ffba_pkg::CMD_ALLOC;
            cap = (mdl_limit < SPAN) ? mdl_limit : (ADDR_W+1)'(SPAN);
            k   = int'(cap) - int'(mdl_break) - HDR;
            if (pick < 5)
               r.size = '0;
            else if (pick < 40)
               r.size = ADDR_W'($urandom_range(1, 64));
            else if (pick < 65)
               r.size = ADDR_W'($urandom_range(1, 4096));
            else if (pick < 78 && mdl_count != 0)
               r.size = mdl_len[$urandom_range(mdl_count - 1)];
            else if (pick < 90 && k >= 2)
               // just under, at and over the limit
               r.size = ADDR_W'(k - 1 + int'($urandom_range(0, 2)));
         end else begin
            r.command = ffba_pkg::CMD_FREE;
            if (pick < 8)
               r.address = '0;
            else if (pick < 20 || mdl_count == 0)
               ;
            else if (pick < 45)
               r.address = ADDR_W'(mdl_base[mdl_count - 1] + HDR);
            else if (pick < 52)
               r.address = ADDR_W'(mdl_base[$urandom_range(mdl_count - 1)] + HDR +
                                   $urandom_range(1, 15));
            else
               r.address = ADDR_W'(mdl_base[$urandom_range(mdl_count - 1)] + HDR);
         end
         pending_requests.push_back(r);
      end
   endtask

   initial begin
      mdl_count = 0;
      mdl_break = '0;
      mdl_limit = (ADDR_W+1)'(SPAN);
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      queue_op(ffba_pkg::CMD_ALLOC, 0, 0);
      queue_op(ffba_pkg::CMD_FREE, 0, 0);
      queue_op(ffba_pkg::CMD_FREE, 0, 'h12345);
      queue_op(ffba_pkg::CMD_ALLOC, 1, 0);
      queue_op(ffba_pkg::CMD_ALLOC, 100, 0);
      queue_op(ffba_pkg::CMD_ALLOC, 'hFFFFF, 0);
      queue_op(ffba_pkg::CMD_FREE, 0, 16);
      queue_op(ffba_pkg::CMD_FREE, 0, 16);          // double free of a lower block
      queue_op(ffba_pkg::CMD_ALLOC, 2, 0);
      queue_op(ffba_pkg::CMD_ALLOC, 1, 0);          // reuses the freed first block
      queue_op(ffba_pkg::CMD_FREE, 0, 149);
      queue_op(ffba_pkg::CMD_FREE, 0, 149);         // already popped
      queue_op(ffba_pkg::CMD_FREE, 0, 33);
      queue_op(ffba_pkg::CMD_FREE, 0, 16);
      queue_op(ffba_pkg::CMD_ALLOC, SPAN - HDR, 0); // fills the heap exactly
      queue_op(ffba_pkg::CMD_ALLOC, 1, 0);
      queue_op(ffba_pkg::CMD_FREE, 0, 16);
      queue_op(ffba_pkg::CMD_FREE, 'hFFFFF, 'hFFFFF);
      queue_op(ffba_pkg::CMD_ALLOC, 8, 0);
      queue_op(ffba_pkg::CMD_ALLOC, 8, 0);
      queue_op(ffba_pkg::CMD_ALLOC, 8, 0);
      queue_op(ffba_pkg::CMD_FREE, 0, 40);
      queue_op(ffba_pkg::CMD_FREE, 0, 64);          // pop leaves the free block below in place
      queue_op(ffba_pkg::CMD_ALLOC, 8, 0);
      settle_heap();

      run_phase(230, 60, 1'b1);
      settle_heap();
      write_heap_limit(SPAN);
      run_phase(200, 85, 1'b1);
      settle_heap();
      // limit at most the larger of the current break and HDR: only reuse can succeed
      write_heap_limit(mdl_break > HDR ? $urandom_range(HDR, mdl_break) : HDR);
      run_phase(150, 50, 1'b1);
      settle_heap();
      write_heap_limit(HDR);
      run_phase(60, 60, 1'b1);
      settle_heap();
      write_heap_limit($urandom_range(HDR, SPAN));
      run_phase(150, 60, 1'b1);
      settle_heap();
      write_heap_limit(SPAN);
      run_phase(180, 60, 1'b0);
      settle_heap();

      repeat (80) @(posedge clock);
      if (predicted_outcomes.size() != 0) begin
         if (error_count < 10)
            $display("%0d results never arrived", predicted_outcomes.size());
         error_count += predicted_outcomes.size();
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ffba_pkg.sv
rtl/ffba_table.sv
rtl/ffba_ctrl.sv
rtl/first_fit_block_allocator.sv
rtl/ffba_chk.sv
tb/first_fit_block_allocator_tb.sv
